// File: sv/glw_pkg.sv
package glw_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   localparam int CODE_W   = 32;
   localparam int GWIDTH_W = 8;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int SUM_W    = 16;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_HEIGHT = 8'd1;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_MEASURE = 1'b1;

   localparam logic [HEIGHT_W-1:0] FONT_HEIGHT_RESET = 8'd16;
   localparam logic [SUM_W-1:0]    SUM_MAX           = 16'hFFFF;

   typedef struct packed {
      logic [COUNT_W-1:0]  glyph_count;
      logic [HEIGHT_W-1:0] font_height;
   } glw_cfg_type;

endpackage

// File: sv/glw_if.sv
interface glw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [glw_pkg::INDEX_W-1:0]   entry_index;
   logic [glw_pkg::CODE_W-1:0]    entry_code;
   logic [glw_pkg::GWIDTH_W-1:0]  entry_width;
   logic [glw_pkg::CODE_W-1:0]    char_code;
   logic                          last_char;

   modport source (output valid, mode, entry_index, entry_code, entry_width, char_code,
                   last_char, input ready);
   modport sink (input valid, mode, entry_index, entry_code, entry_width, char_code,
                 last_char, output ready);
endinterface

interface glw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [glw_pkg::GWIDTH_W-1:0]  char_width;
   logic [glw_pkg::SUM_W-1:0]     total_width;
   logic [glw_pkg::HEIGHT_W-1:0]  line_height;
   logic                          string_done;

   modport source (output valid, found, char_width, total_width, line_height, string_done,
                   input ready);
   modport sink (input valid, found, char_width, total_width, line_height, string_done,
                 output ready);
endinterface

interface glw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [glw_pkg::CSR_INDEX_W-1:0]  index;
   logic [glw_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/glyph_width_measure.sv
// Measures string widths against a glyph table of character codes sorted ascending, each
// with a pixel width. A load item writes one table slot and gives no result, and leaves
// the block ready for the next item. A measure item binary-searches the first glyph_count
// entries (clamped to the table depth) and returns one result; a missing code gets half
// the font height. The search reads the table once per cycle through its single read port
// and makes at most floor(log2(n)) + 1 probes; no new item is taken until the result is
// written. Results sit in an output register, so the next item is taken while a result
// waits. Entries never loaded read back as undefined.
module glyph_width_measure #(
   parameter int TABLE_DEPTH = glw_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   glw_req_if.sink   req_ch,
   glw_rsp_if.source rsp_ch,
   glw_csr_if.sink   csr_ch
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   glw_pkg::glw_cfg_type            cfg_ff, cfg_in;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [glw_pkg::CODE_W-1:0]      wr_key;
   logic [glw_pkg::GWIDTH_W-1:0]    wr_width;
   logic [ADDR_W-1:0]               rd_addr;
   logic [glw_pkg::CODE_W-1:0]      rd_key;
   logic [glw_pkg::GWIDTH_W-1:0]    rd_width;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            glw_pkg::CSR_GLYPH_COUNT: cfg_in.glyph_count = csr_ch.data[glw_pkg::COUNT_W-1:0];
            glw_pkg::CSR_FONT_HEIGHT: cfg_in.font_height = csr_ch.data[glw_pkg::HEIGHT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_count <= '0;
         cfg_ff.font_height <= glw_pkg::FONT_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   glw_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_width (wr_width),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_width (rd_width)
   );

   glw_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_width (wr_width),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_width (rd_width)
   );

   a_total_covers_char: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (glw_pkg::SUM_W'(rsp_ch.char_width) <= rsp_ch.total_width))
      else $error("running width below the width of its own item");

   a_height_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.string_done) |-> (rsp_ch.line_height == '0))
      else $error("line height reported before the end of the string");

   a_saturated_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.string_done
       && (rsp_ch.total_width == glw_pkg::SUM_MAX))
      ##1 (rsp_ch.valid && rsp_ch.ready) |-> (rsp_ch.total_width == glw_pkg::SUM_MAX))
      else $error("saturated running width dropped inside a string");

endmodule

// File: sv/glw_table.sv
module glw_table #(
   parameter int TABLE_DEPTH = glw_pkg::DEFAULT_TABLE_DEPTH,
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [glw_pkg::CODE_W-1:0]    wr_key,
   input  logic [glw_pkg::GWIDTH_W-1:0]  wr_width,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [glw_pkg::CODE_W-1:0]    rd_key,
   output logic [glw_pkg::GWIDTH_W-1:0]  rd_width
);

   logic [glw_pkg::CODE_W-1:0]   key_mem   [TABLE_DEPTH];
   logic [glw_pkg::GWIDTH_W-1:0] width_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         width_mem[wr_addr] <= wr_width;
      end
      rd_key   <= key_mem[rd_addr];
      rd_width <= width_mem[rd_addr];
   end

endmodule

// File: sv/glw_engine.sv
module glw_engine #(
   parameter int TABLE_DEPTH = glw_pkg::DEFAULT_TABLE_DEPTH,
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  glw_pkg::glw_cfg_type          cfg,
   glw_req_if.sink                       req,
   glw_rsp_if.source                     rsp,
   output logic                          wr_en,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [glw_pkg::CODE_W-1:0]    wr_key,
   output logic [glw_pkg::GWIDTH_W-1:0]  wr_width,
   output logic [ADDR_W-1:0]             rd_addr,
   input  logic [glw_pkg::CODE_W-1:0]    rd_key,
   input  logic [glw_pkg::GWIDTH_W-1:0]  rd_width
);

   typedef enum logic [1:0] {IDLE, PROBE, DONE} state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               lo_ff, lo_in;
   logic [CNT_W-1:0]               hip_ff, hip_in;   // upper bound, exclusive
   logic [CNT_W-1:0]               mid_ff, mid_in;
   logic [glw_pkg::CODE_W-1:0]     code_ff, code_in;
   logic                           last_ff, last_in;
   logic                           hit_ff, hit_in;
   logic [glw_pkg::GWIDTH_W-1:0]   hitw_ff, hitw_in;
   logic [glw_pkg::SUM_W-1:0]      sum_ff, sum_in;

   logic                           rvalid_ff, rvalid_in;
   logic                           found_ff, found_in;
   logic [glw_pkg::GWIDTH_W-1:0]   cw_ff, cw_in;
   logic [glw_pkg::SUM_W-1:0]      total_ff, total_in;
   logic [glw_pkg::HEIGHT_W-1:0]   lh_ff, lh_in;
   logic                           done_ff, done_in;

   logic                           accept;
   logic [CNT_W-1:0]               count_n;
   logic [CNT_W-1:0]               lo_n, hip_n;
   logic [CNT_W:0]                 mid_sum;
   logic [CNT_W:0]                 mid_sum0;
   logic [glw_pkg::GWIDTH_W-1:0]   w;
   logic [glw_pkg::SUM_W:0]        sum_wide;
   logic [glw_pkg::SUM_W-1:0]      sum_sat;

   assign accept   = req.valid && req.ready;
   assign count_n  = (32'(cfg.glyph_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(cfg.glyph_count);

   assign wr_en    = accept && (req.mode == glw_pkg::MODE_LOAD)
                     && (32'(req.entry_index) < TABLE_DEPTH);
   assign wr_addr  = ADDR_W'(req.entry_index);
   assign wr_key   = req.entry_code;
   assign wr_width = req.entry_width;
   assign rd_addr  = ADDR_W'(mid_in);

   assign mid_sum0 = {1'b0, count_n} - (CNT_W+1)'(1);
   assign mid_sum  = {1'b0, lo_n} + {1'b0, hip_n} - (CNT_W+1)'(1);

   assign w        = hit_ff ? hitw_ff : (cfg.font_height >> 1);
   assign sum_wide = {1'b0, sum_ff} + (glw_pkg::SUM_W+1)'(w);
   assign sum_sat  = sum_wide[glw_pkg::SUM_W] ? glw_pkg::SUM_MAX
                                              : sum_wide[glw_pkg::SUM_W-1:0];

   assign req.ready       = (state_ff == IDLE);
   assign rsp.valid       = rvalid_ff;
   assign rsp.found       = found_ff;
   assign rsp.char_width  = cw_ff;
   assign rsp.total_width = total_ff;
   assign rsp.line_height = lh_ff;
   assign rsp.string_done = done_ff;

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hip_in    = hip_ff;
      mid_in    = mid_ff;
      code_in   = code_ff;
      last_in   = last_ff;
      hit_in    = hit_ff;
      hitw_in   = hitw_ff;
      sum_in    = sum_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      found_in  = found_ff;
      cw_in     = cw_ff;
      total_in  = total_ff;
      lh_in     = lh_ff;
      done_in   = done_ff;
      lo_n      = lo_ff;
      hip_n     = hip_ff;

      unique case (state_ff)
         IDLE: begin
            if (accept && (req.mode == glw_pkg::MODE_MEASURE)) begin
               code_in  = req.char_code;
               last_in  = req.last_char;
               hit_in   = 1'b0;
               lo_in    = '0;
               hip_in   = count_n;
               mid_in   = CNT_W'(mid_sum0 >> 1);
               state_in = (count_n == '0) ? DONE : PROBE;
            end
         end
         PROBE: begin
            if (rd_key == code_ff) begin
               hit_in   = 1'b1;
               hitw_in  = rd_width;
               state_in = DONE;
            end else begin
               if (rd_key < code_ff) begin
                  lo_n = mid_ff + CNT_W'(1);
               end else begin
                  hip_n = mid_ff;
               end
               lo_in  = lo_n;
               hip_in = hip_n;
               if (lo_n < hip_n) begin
                  mid_in = CNT_W'(mid_sum >> 1);
               end else begin
                  state_in = DONE;
               end
            end
         end
         DONE: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
               found_in  = hit_ff;
               cw_in     = w;
               total_in  = sum_sat;
               lh_in     = last_ff ? cfg.font_height : '0;
               done_in   = last_ff;
               sum_in    = last_ff ? '0 : sum_sat;
               state_in  = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         rvalid_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         sum_ff    <= sum_in;
      end
      lo_ff    <= lo_in;
      hip_ff   <= hip_in;
      mid_ff   <= mid_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
      hit_ff   <= hit_in;
      hitw_ff  <= hitw_in;
      found_ff <= found_in;
      cw_ff    <= cw_in;
      total_ff <= total_in;
      lh_ff    <= lh_in;
      done_ff  <= done_in;
   end

endmodule

// File: test/glw_measure_checker.sv
`timescale 1ns / 1ps

module glw_measure_checker #(
   parameter int TABLE_DEPTH = glw_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   glw_req_if   req_mon,
   glw_rsp_if   rsp_mon,
   glw_csr_if   csr_mon,
   output int   fail_count,
   output int   results_due
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [glw_pkg::SUM_W:0] SUM_CEIL = {1'b0, glw_pkg::SUM_MAX};

   typedef struct packed {
      logic                         found;
      logic [glw_pkg::GWIDTH_W-1:0] char_width;
      logic [glw_pkg::SUM_W-1:0]    total_width;
      logic [glw_pkg::HEIGHT_W-1:0] line_height;
      logic                         string_done;
   } width_result_type;

   logic [glw_pkg::CODE_W-1:0]   key_copy   [TABLE_DEPTH];
   logic [glw_pkg::GWIDTH_W-1:0] width_copy [TABLE_DEPTH];
   logic [glw_pkg::SUM_W-1:0]    string_sum = '0;
   glw_pkg::glw_cfg_type         cfg_copy;
   width_result_type             widths_due [$];
   int                           mismatches = 0;
   int                           due_count  = 0;

   assign fail_count  = mismatches;
   assign results_due = due_count;

   task automatic report_mismatch(input string note);
      if (mismatches < 100)
         $display("%0t ns: %s", $time, note);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", field, got, want));
   endtask

   function automatic logic search_glyph(input logic [glw_pkg::CODE_W-1:0] code,
                                         input int entries,
                                         output logic [glw_pkg::GWIDTH_W-1:0] hit_width);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = entries - 1;
      hit_width = '0;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (key_copy[ADDR_W'(mid)] < code) begin
            lo = mid + 1;
         end else if (key_copy[ADDR_W'(mid)] == code) begin
            hit_width = width_copy[ADDR_W'(mid)];
            return 1'b1;
         end else begin
            hi = mid - 1;
         end
      end
      return 1'b0;
   endfunction

   // updates the running string width as a side effect
   function automatic width_result_type measure_char(input logic [glw_pkg::CODE_W-1:0] code,
                                                     input logic last);
      width_result_type             res;
      int                           entries;
      logic [glw_pkg::GWIDTH_W-1:0] w;
      logic [glw_pkg::SUM_W:0]      sum;
      entries = (int'(cfg_copy.glyph_count) > TABLE_DEPTH) ? TABLE_DEPTH
                                                           : int'(cfg_copy.glyph_count);
      res.found = search_glyph(code, entries, w);
      if (!res.found)
         w = cfg_copy.font_height >> 1;
      sum = {1'b0, string_sum} + (glw_pkg::SUM_W+1)'(w);
      if (sum > SUM_CEIL)
         sum = SUM_CEIL;
      res.char_width  = w;
      res.total_width = sum[glw_pkg::SUM_W-1:0];
      res.line_height = last ? cfg_copy.font_height : '0;
      res.string_done = last;
      string_sum = last ? '0 : sum[glw_pkg::SUM_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      width_result_type want;
      if (reset) begin
         string_sum = '0;
         cfg_copy.glyph_count = '0;
         cfg_copy.font_height = glw_pkg::FONT_HEIGHT_RESET;
         widths_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (widths_due.size() == 0) begin
               report_mismatch($sformatf("result with none due: total_width 0x%0h",
                                         rsp_mon.total_width));
            end else begin
               want = widths_due.pop_front();
               check_field("found", 32'(rsp_mon.found), 32'(want.found));
               check_field("char_width", 32'(rsp_mon.char_width), 32'(want.char_width));
               check_field("total_width", 32'(rsp_mon.total_width), 32'(want.total_width));
               check_field("line_height", 32'(rsp_mon.line_height), 32'(want.line_height));
               check_field("string_done", 32'(rsp_mon.string_done), 32'(want.string_done));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               glw_pkg::CSR_GLYPH_COUNT:
                  cfg_copy.glyph_count = csr_mon.data[glw_pkg::COUNT_W-1:0];
               glw_pkg::CSR_FONT_HEIGHT:
                  cfg_copy.font_height = csr_mon.data[glw_pkg::HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.mode == glw_pkg::MODE_LOAD) begin
               if (int'(req_mon.entry_index) < TABLE_DEPTH) begin
                  key_copy[ADDR_W'(req_mon.entry_index)]   = req_mon.entry_code;
                  width_copy[ADDR_W'(req_mon.entry_index)] = req_mon.entry_width;
               end
            end else begin
               widths_due.push_back(measure_char(req_mon.char_code, req_mon.last_char));
            end
         end
      end
      due_count = widths_due.size();
   end

endmodule

// File: test/tb_glyph_width_measure.sv
`timescale 1ns / 1ps

module tb_glyph_width_measure;

   localparam int DEPTH         = glw_pkg::DEFAULT_TABLE_DEPTH;
   localparam int SLOT_W        = $clog2(DEPTH);
   localparam int ITEM_TARGET   = 1250;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [glw_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 8'd2;
   localparam logic [glw_pkg::CSR_INDEX_W-1:0] CSR_LAST  = 8'hFF;
   localparam logic [glw_pkg::CODE_W-1:0]      CODE_TOP  = '1;

   typedef struct {
      logic                         mode;
      logic [glw_pkg::INDEX_W-1:0]  entry_index;
      logic [glw_pkg::CODE_W-1:0]   entry_code;
      logic [glw_pkg::GWIDTH_W-1:0] entry_width;
      logic [glw_pkg::CODE_W-1:0]   char_code;
      logic                         last_char;
   } glyph_item_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_pattern_type;

   logic                        clock;
   logic                        reset;
   int                          fail_count;
   int                          results_due;
   int                          cycle_count = 0;
   int                          items_sent  = 0;
   int                          burst_left  = 0;
   logic [glw_pkg::CODE_W-1:0]  codes_loaded [DEPTH];
   logic [glw_pkg::COUNT_W-1:0] active_count = '0;

   glw_req_if req_bus ();
   glw_rsp_if rsp_bus ();
   glw_csr_if csr_bus ();

   glyph_width_measure DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   glw_measure_checker u_measure_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result side stalls on a pattern of its own
   initial begin
      rx_pattern_type pattern;
      int             pattern_left;
      int             hold_left;
      pattern      = RX_OPEN;
      pattern_left = 0;
      hold_left    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pattern_left == 0) begin
            pattern      = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         case (pattern)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (hold_left == 0)
                  hold_left = $urandom_range(1, 30);
               hold_left--;
               rsp_bus.ready <= (hold_left == 0);
            end
         endcase
      end
   end

   task automatic push_item(input glyph_item_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= item.mode;
      req_bus.entry_index <= item.entry_index;
      req_bus.entry_code  <= item.entry_code;
      req_bus.entry_width <= item.entry_width;
      req_bus.char_code   <= item.char_code;
      req_bus.last_char   <= item.last_char;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      items_sent++;
      if (item.mode == glw_pkg::MODE_LOAD)
         codes_loaded[SLOT_W'(item.entry_index)] = item.entry_code;
   endtask

   task automatic load_glyph(input int slot, input logic [glw_pkg::CODE_W-1:0] code,
                             input logic [glw_pkg::GWIDTH_W-1:0] width);
      glyph_item_type item;
      item.mode        = glw_pkg::MODE_LOAD;
      item.entry_index = slot[glw_pkg::INDEX_W-1:0];
      item.entry_code  = code;
      item.entry_width = width;
      item.char_code   = $urandom;
      item.last_char   = ($urandom_range(0, 1) == 1);
      push_item(item);
   endtask

   task automatic measure_glyph(input logic [glw_pkg::CODE_W-1:0] code, input logic last);
      glyph_item_type item;
      item.mode        = glw_pkg::MODE_MEASURE;
      item.entry_index = glw_pkg::INDEX_W'($urandom_range(0, 255));
      item.entry_code  = $urandom;
      item.entry_width = glw_pkg::GWIDTH_W'($urandom_range(0, 255));
      item.char_code   = code;
      item.last_char   = last;
      push_item(item);
   endtask

   task automatic write_csr(input logic [glw_pkg::CSR_INDEX_W-1:0] index,
                            input logic [glw_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      if (index == glw_pkg::CSR_GLYPH_COUNT)
         active_count = data;
   endtask

   // hold off until every result is back and any load has settled
   task automatic drain;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ascending codes, steps of 0 give duplicates, never a step of 1
   task automatic fill_sorted(input int slots, input logic [glw_pkg::CODE_W-1:0] base);
      logic [glw_pkg::CODE_W-1:0] code;
      int                         s;
      code = base;
      for (s = 0; s < slots; s++) begin
         if (s > 0)
            code += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(2, 24'hFFFFFF);
         load_glyph(s, code, glw_pkg::GWIDTH_W'($urandom_range(0, 255)));
      end
   endtask

   function automatic logic [glw_pkg::CODE_W-1:0] pick_code();
      int                         span;
      int                         roll;
      logic [glw_pkg::CODE_W-1:0] known;
      span  = (int'(active_count) > DEPTH) ? DEPTH : int'(active_count);
      known = codes_loaded[SLOT_W'($urandom_range(0, (span > 0) ? span - 1 : DEPTH - 1))];
      roll  = $urandom_range(0, 99);
      if (roll < 60 && span > 0)
         return known;
      if (roll < 70)
         return known + 1;
      if (roll < 78)
         return known - 1;
      if (roll < 82)
         return '0;
      if (roll < 86)
         return CODE_TOP;
      return $urandom;
   endfunction

   task automatic pick_config;
      int                             roll;
      logic [glw_pkg::CSR_DATA_W-1:0] count;
      logic [glw_pkg::CSR_DATA_W-1:0] height;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       count = '0;
         1:       count = 9'd1;
         2, 3:    count = glw_pkg::CSR_DATA_W'($urandom_range(2, 32));
         4:       count = 9'd255;
         5:       count = 9'd256;
         6:       count = glw_pkg::CSR_DATA_W'($urandom_range(257, 511));
         default: count = glw_pkg::CSR_DATA_W'($urandom_range(33, 256));
      endcase
      roll = $urandom_range(0, 5);
      case (roll)
         0:       height = '0;
         1:       height = 9'd255;
         2:       height = 9'd1;
         default: height = glw_pkg::CSR_DATA_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 3) == 0)
         write_csr(glw_pkg::CSR_INDEX_W'($urandom_range(CSR_SPARE, CSR_LAST)),
                   glw_pkg::CSR_DATA_W'($urandom_range(0, 511)));
      if ($urandom_range(0, 1) == 1) begin
         write_csr(glw_pkg::CSR_GLYPH_COUNT, count);
         write_csr(glw_pkg::CSR_FONT_HEIGHT, height);
      end else begin
         write_csr(glw_pkg::CSR_FONT_HEIGHT, height);
         write_csr(glw_pkg::CSR_GLYPH_COUNT, count);
      end
      // small tables get fresh sorted contents
      if (count > 0 && count <= 32)
         fill_sorted(int'(count), $urandom_range(0, 32'hE0000000));
   endtask

   task automatic run_phase(input int items);
      int n;
      int slot;
      int string_left;
      string_left = 0;
      for (n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < 8) begin
            // mostly width updates in place; the rest unsort the table
            slot = $urandom_range(0, DEPTH - 1);
            load_glyph(slot,
                       ($urandom_range(0, 9) < 7) ? codes_loaded[SLOT_W'(slot)] : $urandom,
                       glw_pkg::GWIDTH_W'($urandom_range(0, 255)));
         end else begin
            if (string_left == 0)
               string_left = $urandom_range(1, 12);
            string_left--;
            measure_glyph(pick_code(), string_left == 0);
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= glw_pkg::MODE_LOAD;
      req_bus.entry_index <= '0;
      req_bus.entry_code  <= '0;
      req_bus.entry_width <= '0;
      req_bus.char_code   <= '0;
      req_bus.last_char   <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= glw_pkg::CSR_GLYPH_COUNT;
      csr_bus.data        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_csr(glw_pkg::CSR_GLYPH_COUNT, glw_pkg::CSR_DATA_W'(DEPTH));
      write_csr(glw_pkg::CSR_FONT_HEIGHT, 9'd255);
      fill_sorted(DEPTH, '0);
      load_glyph(101, codes_loaded[100], 8'd7);
      load_glyph(DEPTH - 1, CODE_TOP, 8'hFF);

      measure_glyph('0, 1'b0);
      measure_glyph(CODE_TOP, 1'b0);
      measure_glyph(codes_loaded[101], 1'b0);
      measure_glyph(codes_loaded[10] + 1, 1'b1);
      measure_glyph(CODE_TOP - 1, 1'b1);

      // writes to unused register indexes change nothing
      drain;
      write_csr(CSR_SPARE, '1);
      write_csr(CSR_LAST, '0);
      measure_glyph(codes_loaded[37], 1'b1);

      // empty table
      drain;
      write_csr(glw_pkg::CSR_GLYPH_COUNT, '0);
      write_csr(glw_pkg::CSR_FONT_HEIGHT, '0);
      measure_glyph('0, 1'b0);
      drain;
      write_csr(glw_pkg::CSR_FONT_HEIGHT, 9'd1);
      measure_glyph(CODE_TOP, 1'b0);
      drain;
      write_csr(glw_pkg::CSR_FONT_HEIGHT, 9'd254);
      measure_glyph(codes_loaded[5], 1'b1);

      // count beyond the table depth
      drain;
      write_csr(glw_pkg::CSR_GLYPH_COUNT, 9'd511);
      measure_glyph(CODE_TOP, 1'b0);
      measure_glyph(codes_loaded[200], 1'b1);
      drain;
      write_csr(glw_pkg::CSR_GLYPH_COUNT, 9'd257);
      measure_glyph('0, 1'b1);

      drain;
      write_csr(glw_pkg::CSR_GLYPH_COUNT, 9'd1);
      measure_glyph(codes_loaded[0], 1'b0);
      measure_glyph(codes_loaded[1], 1'b1);
      load_glyph(0, '0, 8'd200);
      measure_glyph('0, 1'b1);

      // long string of widest glyphs runs the total into saturation
      drain;
      write_csr(glw_pkg::CSR_GLYPH_COUNT, glw_pkg::CSR_DATA_W'(DEPTH));
      repeat (299) measure_glyph(CODE_TOP, 1'b0);
      measure_glyph(CODE_TOP, 1'b1);
      measure_glyph(CODE_TOP, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         drain;
         pick_config;
         run_phase($urandom_range(30, 90));
      end
      drain;

      if (fail_count == 0 && results_due == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
